### hw/rtl/iambic_morse_keyer_macros.svh
// ----------------------------------------------------------------------------
// Iambic Morse keyer assertion macros
// Shared wrappers for concurrent checks on clk with active-low reset.
// ----------------------------------------------------------------------------
`ifndef IAMBIC_MORSE_KEYER_MACROS_SVH
`define IAMBIC_MORSE_KEYER_MACROS_SVH

// same-cycle implication
`define IMK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imk check failed");

// next-cycle implication
`define IMK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imk check failed");

`endif

### hw/rtl/imk_pkg.sv
// ----------------------------------------------------------------------------
// imk_pkg
// Types and constants shared by the iambic Morse keyer modules.
// ----------------------------------------------------------------------------
package imk_pkg;

    localparam int TIME_BITS = 32;
    localparam int NOW_W     = 32;
    localparam int POT_W     = 12;
    localparam int UNIT_W    = 7;
    localparam int WPM_W     = 6;
    localparam int EL_W      = 2;

    localparam int POT_FULL   = 4096;
    localparam int WPM_SPAN   = 25;
    localparam int WPM_MIN    = 10;
    localparam int DIVIDEND   = (60 * 1000) / 50;
    localparam int DIVD_W     = $clog2(DIVIDEND + 1);
    localparam int DIV_STEPS  = DIVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int UNIT_RESET = 63;
    localparam int UNIT_MIN   = 34;
    localparam int UNIT_MAX   = 120;

    localparam logic [EL_W-1:0] EL_NONE = 2'd0;
    localparam logic [EL_W-1:0] EL_DIT  = 2'd1;
    localparam logic [EL_W-1:0] EL_DAH  = 2'd2;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [UNIT_W-1:0]    unit_t;

    typedef struct packed {
        time_t now;
        logic  dit;
        logic  dah;
        logic  bypass;
    } poll_t;

    typedef struct packed {
        logic            key;
        logic            busy;
        logic [EL_W-1:0] prev;
    } key_state_t;

endpackage

### hw/rtl/imk_if.sv
// ----------------------------------------------------------------------------
// imk_in_if / imk_out_if
// Valid/ready channels for paddle polls and keyer results.
// ----------------------------------------------------------------------------
interface imk_in_if;
    logic                       valid;
    logic                       ready;
    logic [imk_pkg::NOW_W-1:0]  now_ms;
    logic                       dit_paddle;
    logic                       dah_paddle;
    logic                       bypass;
    logic [imk_pkg::POT_W-1:0]  speed_pot;

    modport source (output valid, now_ms, dit_paddle, dah_paddle, bypass, speed_pot,
                    input ready);
    modport sink   (input valid, now_ms, dit_paddle, dah_paddle, bypass, speed_pot,
                    output ready);
endinterface

interface imk_out_if;
    logic                       valid;
    logic                       ready;
    logic                       key_out;
    logic                       sending;
    logic [imk_pkg::EL_W-1:0]   last_element;

    modport source (output valid, key_out, sending, last_element, input ready);
    modport sink   (input valid, key_out, sending, last_element, output ready);
endinterface

### hw/rtl/iambic_morse_keyer.sv
// A poll passes the key, divide and output states before its result becomes valid.
// The next poll waits until the 11-step shared divider for the unit time is done.
// Input ready is high only while the sequencer is idle; a pending result may wait meanwhile.
// Reset (rst_n low, asynchronous) gives key up, no element, all timers 0, unit 63 ms.
// ----------------------------------------------------------------------------
// iambic_morse_keyer
// Top level: poll sequencer, iambic keyer engine and shared speed divider.
// ----------------------------------------------------------------------------
`include "iambic_morse_keyer_macros.svh"

module iambic_morse_keyer (
    input  logic      clk,
    input  logic      rst_n,
    imk_in_if.sink    in_ch,
    imk_out_if.source out_ch
);
    import imk_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_KEY  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    poll_t            poll_reg, poll_next;
    logic [POT_W-1:0] pot_reg, pot_next;
    logic             oval_reg, oval_next;
    key_state_t       res_reg, res_next;

    logic             accept;
    logic             step;
    logic             div_done;
    unit_t            unit;
    key_state_t       key_st;

    imk_keyer u_keyer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .poll    (poll_reg),
        .unit_wr (div_done),
        .unit_in (unit),
        .state   (key_st)
    );

    imk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (step),
        .pot   (pot_reg),
        .done  (div_done),
        .unit  (unit)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign step        = (state_reg == ST_KEY);

    always_comb
    begin
        state_next = state_reg;
        poll_next  = poll_reg;
        pot_next   = pot_reg;
        res_next   = res_reg;
        oval_next  = oval_reg && !out_ch.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    poll_next.now    = time_t'(in_ch.now_ms);
                    poll_next.dit    = in_ch.dit_paddle;
                    poll_next.dah    = in_ch.dah_paddle;
                    poll_next.bypass = in_ch.bypass;
                    pot_next         = in_ch.speed_pot;
                    state_next       = ST_KEY;
                end
            end
            ST_KEY:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!oval_reg || out_ch.ready)
                begin
                    res_next   = key_st;
                    oval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        poll_reg <= poll_next;
        pot_reg  <= pot_next;
        res_reg  <= res_next;
    end

    assign out_ch.valid        = oval_reg;
    assign out_ch.key_out      = res_reg.key;
    assign out_ch.sending      = res_reg.busy;
    assign out_ch.last_element = res_reg.prev;

    `IMK_ASSERT_NEXT(a_accept_to_key, accept, state_reg == ST_KEY)
    `IMK_ASSERT_NOW(a_done_in_div, div_done, state_reg == ST_DIV)
    `IMK_ASSERT_NOW(a_unit_range, div_done, unit >= UNIT_W'(UNIT_MIN) && unit <= UNIT_W'(UNIT_MAX))
    `IMK_ASSERT_NOW(a_busy_has_element, key_st.busy, key_st.prev != EL_NONE)

endmodule

### hw/rtl/imk_div.sv
// ----------------------------------------------------------------------------
// imk_div
// Speed pot to wpm mapping and a one-bit-per-cycle restoring divider
// that yields the unit time 1200/wpm.
// ----------------------------------------------------------------------------
module imk_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [imk_pkg::POT_W-1:0] pot,
    output logic                      done,
    output imk_pkg::unit_t            unit
);
    import imk_pkg::*;

    logic [POT_W:0]       span;
    logic [POT_W+5:0]     scaled;
    logic [WPM_W-1:0]     wpm;
    logic [WPM_W:0]       trial;
    logic                 geq;

    logic [WPM_W-1:0]     rem_reg, rem_next;
    logic [DIVD_W-1:0]    quot_reg, quot_next;
    logic [WPM_W-1:0]     div_reg, div_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        span   = (POT_W+1)'(POT_FULL) - {1'b0, pot};
        scaled = (POT_W+6)'(span) * (POT_W+6)'(WPM_SPAN);
        wpm    = WPM_W'(scaled >> POT_W) + WPM_W'(WPM_MIN);
        trial  = {rem_reg, quot_reg[DIVD_W-1]};
        geq    = trial >= {1'b0, div_reg};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quot_next = DIVD_W'(DIVIDEND);
            div_next  = wpm;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = geq ? WPM_W'(trial - {1'b0, div_reg}) : WPM_W'(trial);
            quot_next = {quot_reg[DIVD_W-2:0], geq};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
    end

    assign done = done_reg;
    assign unit = quot_reg[UNIT_W-1:0];

endmodule

### hw/rtl/imk_keyer.sv
// ----------------------------------------------------------------------------
// imk_keyer
// Iambic element engine: key level, element timers, element memory and
// the unit time register.
// ----------------------------------------------------------------------------
module imk_keyer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  imk_pkg::poll_t      poll,
    input  logic                unit_wr,
    input  imk_pkg::unit_t      unit_in,
    output imk_pkg::key_state_t state
);
    import imk_pkg::*;

    logic            key_reg, key_next;
    logic            busy_reg, busy_next;
    time_t           end_reg, end_next;
    time_t           read_reg, read_next;
    time_t           nsa_reg, nsa_next;
    logic [EL_W-1:0] prev_reg, prev_next;
    logic [EL_W-1:0] queue_reg, queue_next;
    unit_t           unit_reg, unit_next;

    time_t           u1, u2, u3, u4;
    logic [EL_W-1:0] q;

    always_comb
    begin
        u1 = time_t'(unit_reg);
        u2 = time_t'({unit_reg, 1'b0});
        u3 = u1 + u2;
        u4 = time_t'({unit_reg, 2'b00});

        key_next   = key_reg;
        busy_next  = busy_reg;
        end_next   = end_reg;
        read_next  = read_reg;
        nsa_next   = nsa_reg;
        prev_next  = prev_reg;
        queue_next = queue_reg;
        unit_next  = unit_wr ? unit_in : unit_reg;
        q          = queue_reg;

        if (step && poll.bypass)
        begin
            key_next = poll.dit;
        end
        else if (step)
        begin
            if (busy_reg && poll.now >= end_reg)
            begin
                key_next  = 1'b0;
                busy_next = 1'b0;
            end
            if (queue_reg == EL_NONE)
            begin
                if (poll.dit && prev_reg == EL_DAH)
                    q = EL_DIT;
                else if (poll.dah && prev_reg == EL_DIT)
                    q = EL_DAH;
                else if (poll.now > read_reg)
                begin
                    if (poll.dit)
                        q = EL_DIT;
                    else if (poll.dah)
                        q = EL_DAH;
                end
            end
            queue_next = q;
            if (poll.now > nsa_reg && q != EL_NONE)
            begin
                if (q == EL_DIT)
                begin
                    end_next  = poll.now + u1;
                    read_next = poll.now + u2;
                    nsa_next  = poll.now + u2;
                end
                else
                begin
                    end_next  = poll.now + u3;
                    read_next = poll.now + u3;
                    nsa_next  = poll.now + u4;
                end
                prev_next  = q;
                queue_next = EL_NONE;
                busy_next  = 1'b1;
                key_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= 1'b0;
            busy_reg  <= 1'b0;
            end_reg   <= '0;
            read_reg  <= '0;
            nsa_reg   <= '0;
            prev_reg  <= EL_NONE;
            queue_reg <= EL_NONE;
            unit_reg  <= UNIT_W'(UNIT_RESET);
        end
        else
        begin
            key_reg   <= key_next;
            busy_reg  <= busy_next;
            end_reg   <= end_next;
            read_reg  <= read_next;
            nsa_reg   <= nsa_next;
            prev_reg  <= prev_next;
            queue_reg <= queue_next;
            unit_reg  <= unit_next;
        end
    end

    assign state.key  = key_reg;
    assign state.busy = busy_reg;
    assign state.prev = prev_reg;

endmodule

### tb/iambic_morse_keyer_test.sv
// ----------------------------------------------------------------------------
// iambic_morse_keyer_test
// Self-checking bench for the iambic Morse keyer. Polls go in on the input
// channel and each result is compared with a cycle-free keyer model kept in
// the bench, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module iambic_morse_keyer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import imk_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP     = 11;
    localparam int SETTLE      = 40;
    localparam int PRINT_LIMIT = 50;

    typedef struct packed {
        time_t            now;
        logic             dit;
        logic             dah;
        logic             byp;
        logic [POT_W-1:0] pot;
    } paddle_poll_t;

    logic clk;
    logic rst_n;

    imk_in_if  in_ch ();
    imk_out_if out_ch ();

    iambic_morse_keyer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    logic            key_down        = 1'b0;
    logic            element_active  = 1'b0;
    time_t           element_end_ms  = '0;
    time_t           read_after_ms   = '0;
    time_t           start_after_ms  = '0;
    logic [EL_W-1:0] last_started    = EL_NONE;
    logic [EL_W-1:0] pending_element = EL_NONE;
    unit_t           unit_len        = unit_t'(UNIT_RESET);

    key_state_t expected_keys[$];
    int         error_count = 0;
    bit         tx_idle     = 1'b1;
    bit         rx_idle     = 1'b1;
    int         rx_wait     = 0;
    int         rx_hold     = 0;
    time_t      clock_ms    = '0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycles, expected_keys.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic key_state_t keyer_poll(paddle_poll_t p);
        time_t      u;
        int         wpm;
        key_state_t r;
        if (p.byp)
            key_down = p.dit;
        else
        begin
            if (element_active && p.now >= element_end_ms)
            begin
                key_down       = 1'b0;
                element_active = 1'b0;
            end
            if (pending_element == EL_NONE)
            begin
                if (p.dit && last_started == EL_DAH)
                    pending_element = EL_DIT;
                else if (p.dah && last_started == EL_DIT)
                    pending_element = EL_DAH;
                else if (p.now > read_after_ms)
                begin
                    if (p.dit)
                        pending_element = EL_DIT;
                    else if (p.dah)
                        pending_element = EL_DAH;
                end
            end
            if (p.now > start_after_ms && pending_element != EL_NONE)
            begin
                u = time_t'(unit_len);
                if (pending_element == EL_DIT)
                begin
                    element_end_ms = p.now + u;
                    read_after_ms  = p.now + u + u;
                end
                else
                begin
                    element_end_ms = p.now + u + u + u;
                    read_after_ms  = element_end_ms;
                end
                last_started    = pending_element;
                pending_element = EL_NONE;
                start_after_ms  = element_end_ms + u;
                element_active  = 1'b1;
                key_down        = 1'b1;
            end
        end
        wpm      = WPM_MIN + ((POT_FULL - int'(p.pot)) * WPM_SPAN) / POT_FULL;
        unit_len = unit_t'(DIVIDEND / wpm);
        r.key  = key_down;
        r.busy = element_active;
        r.prev = last_started;
        return r;
    endfunction

    function automatic paddle_poll_t mk_poll(time_t now, int dit, int dah, int byp, int pot);
        paddle_poll_t p;
        p.now = now;
        p.dit = dit[0];
        p.dah = dah[0];
        p.byp = byp[0];
        p.pot = pot[POT_W-1:0];
        return p;
    endfunction

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic send_poll(paddle_poll_t p);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.now_ms     <= p.now;
        in_ch.dit_paddle <= p.dit;
        in_ch.dah_paddle <= p.dah;
        in_ch.bypass     <= p.byp;
        in_ch.speed_pot  <= p.pot;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_keys.push_back(keyer_poll(p));
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_keys.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result();
        key_state_t e;
        if (expected_keys.size() == 0)
        begin
            report_mismatch("result with no poll outstanding");
            return;
        end
        e = expected_keys.pop_front();
        if (out_ch.key_out !== e.key)
            report_mismatch($sformatf("key_out got %b expected %b", out_ch.key_out, e.key));
        if (out_ch.sending !== e.busy)
            report_mismatch($sformatf("sending got %b expected %b", out_ch.sending, e.busy));
        if (out_ch.last_element !== e.prev)
            report_mismatch($sformatf("last_element got %0d expected %0d",
                                      out_ch.last_element, e.prev));
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                check_result();
                rx_wait = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ch.ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic run_sequences(int n);
        int               sent;
        int               hold;
        bit               dit;
        bit               dah;
        bit               byp;
        logic [POT_W-1:0] seq_pot;
        logic [POT_W-1:0] pot;
        sent    = 0;
        seq_pot = POT_W'($urandom_range(0, 4095));
        while (sent < n)
        begin
            {dit, dah} = 2'($urandom_range(0, 3));
            byp        = ($urandom_range(0, 15) == 0);
            hold       = $urandom_range(1, 24);
            if ($urandom_range(0, 7) == 0)
                seq_pot = POT_W'($urandom_range(0, 4095));
            if ($urandom_range(0, 7) == 0)
                tx_idle = ~tx_idle;
            if ($urandom_range(0, 7) == 0)
                rx_idle = ~rx_idle;
            repeat (hold)
            begin
                if (sent < n)
                begin
                    pot = ($urandom_range(0, 3) == 0) ? POT_W'($urandom_range(0, 4095))
                                                      : seq_pot;
                    clock_ms = clock_ms + $urandom_range(0, 25);
                    send_poll(mk_poll(clock_ms, int'(dit), int'(dah), int'(byp), int'(pot)));
                    sent++;
                end
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_directed_corners();
        send_poll(mk_poll(32'd0, 1, 0, 0, 2048));
        send_poll(mk_poll(32'd1, 1, 1, 0, 4095));
        send_poll(mk_poll(32'd20, 1, 1, 0, 4095));
        send_poll(mk_poll(32'd60, 1, 1, 0, 0));
        send_poll(mk_poll(32'd110, 1, 1, 0, 0));
        send_poll(mk_poll(32'd150, 0, 0, 1, 0));
        send_poll(mk_poll(32'd151, 1, 0, 1, 0));
        send_poll(mk_poll(32'd212, 0, 0, 0, 0));
        send_poll(mk_poll(32'd300, 1, 0, 1, 4095));
        send_poll(mk_poll(32'd301, 0, 0, 0, 4095));
        send_poll(mk_poll(32'd400, 0, 1, 0, 4095));
        send_poll(mk_poll(32'd760, 0, 0, 0, 4095));
        send_poll(mk_poll(32'd900, 0, 0, 0, 4095));
        send_poll(mk_poll(32'hFFFF_FFFF, 0, 0, 0, 0));
        send_poll(mk_poll(32'hFFFF_FFF0, 0, 1, 0, 0));
        send_poll(mk_poll(32'hFFFF_FFFF, 0, 0, 0, 0));
        send_poll(mk_poll(32'h0000_0010, 1, 0, 0, 0));
        send_poll(mk_poll(32'h0000_0079, 1, 0, 0, 4095));
        send_poll(mk_poll(32'h0000_009B, 0, 1, 0, 4095));
        send_poll(mk_poll(32'h0000_00BE, 0, 0, 0, 4095));
        send_poll(mk_poll(32'h0000_1000, 0, 0, 0, 1));
        send_poll(mk_poll(32'h0000_1000, 1, 0, 1, 4094));
        send_poll(mk_poll(32'h0000_1001, 1, 1, 0, 2047));
        send_poll(mk_poll(32'h0000_1200, 1, 1, 0, 2047));
        clock_ms = 32'h0000_2000;
    endtask

    task automatic test_keying_sequences();
        run_sequences(900);
    endtask

    task automatic test_time_wrap();
        clock_ms = 32'hFFFF_FC00;
        run_sequences(80);
    endtask

    task automatic test_output_stall();
        tx_idle = 1'b0;
        rx_hold = 300;
        repeat (16)
        begin
            clock_ms = clock_ms + $urandom_range(1, 30);
            send_poll(mk_poll(clock_ms, $urandom_range(0, 1), $urandom_range(0, 1), 0,
                              $urandom_range(0, 4095)));
        end
        tx_idle = 1'b1;
    endtask

    task automatic test_drain_pause();
        drain_results();
        run_sequences(20);
        drain_results();
        run_sequences(20);
    endtask

    task automatic test_random_noise();
        time_t now;
        repeat (300)
        begin
            if ($urandom_range(0, 3) == 0)
                now = $urandom;
            else
                now = clock_ms + $urandom_range(0, 200);
            clock_ms = now;
            send_poll(mk_poll(now, $urandom_range(0, 1), $urandom_range(0, 1),
                              $urandom_range(0, 1), $urandom_range(0, 4095)));
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.now_ms       = '0;
        in_ch.dit_paddle   = 1'b0;
        in_ch.dah_paddle   = 1'b0;
        in_ch.bypass       = 1'b0;
        in_ch.speed_pot    = '0;
        out_ch.ready       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_corners();
        test_keying_sequences();
        test_time_wrap();
        test_output_stall();
        test_drain_pause();
        test_random_noise();

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0 && expected_keys.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/imk_pkg.sv
hw/rtl/imk_if.sv
hw/rtl/imk_div.sv
hw/rtl/imk_keyer.sv
hw/rtl/iambic_morse_keyer.sv
tb/iambic_morse_keyer_test.sv
